// ===== rtl/aau_pkg.sv =====
// ----------------------------------------------------------------------------
// aau_pkg
// shared widths, command codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package aau_pkg;

    localparam int DATA_W     = 32;
    localparam int CMD_W      = 3;
    localparam int FACT_LIMIT = 34;

    // command codes carried in a request
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOD  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FACT = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLR  = 3'd6;

    typedef logic [DATA_W-1:0] t_word;

    // datapath micro-operations issued by the controller
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_ALU,
        DP_MUL_INIT,
        DP_MUL_STEP,
        DP_FACT_INIT,
        DP_FACT_STEP,
        DP_X_RES,
        DP_DIV_ZERO,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_FIN,
        DP_COMMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic [CMD_W-1:0] cmd;
    } t_dp_ctl;

    typedef struct packed {
        logic fact_skip;
        logic fact_last;
        logic div_zero;
        logic div_last;
    } t_dp_status;

endpackage

// ===== rtl/aau_req_if.sv =====
// ----------------------------------------------------------------------------
// aau_req_if
// request channel: command and operand with valid/ready
// ----------------------------------------------------------------------------
interface aau_req_if;
    import aau_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic signed [DATA_W-1:0] operand;

    modport source (output valid, output command, output operand, input ready);
    modport sink   (input valid, input command, input operand, output ready);
endinterface

// ===== rtl/aau_rsp_if.sv =====
// ----------------------------------------------------------------------------
// aau_rsp_if
// response channel: accumulator value and divide error flag with valid/ready
// ----------------------------------------------------------------------------
interface aau_rsp_if;
    import aau_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     divide_error;

    modport source (output valid, output value, output divide_error, input ready);
    modport sink   (input valid, input value, input divide_error, output ready);
endinterface

// ===== rtl/accumulator_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// accumulator_arithmetic_unit
// signed 32-bit accumulator calculator with one response per request
// ----------------------------------------------------------------------------
// usage
//   i_req carries a command (add, subtract, multiply, divide, modulo,
//   factorial, clear) and a signed operand; o_rsp returns the new
//   accumulator value and a flag set when divide or modulo by zero was
//   refused (accumulator then left unchanged)
//   one request is worked on at a time; i_req.ready is high while idle
//   states from accept to o_rsp.valid:
//     add, subtract, clear, divide by zero : exec, done
//     multiply                             : exec, mul, x_res, done
//     factorial of n                       : exec, fact, x_res, done
//     divide, modulo                       : exec, 32-step div, fin, done
//   the fact state, a loop over the shared multiplier, is skipped unless
//   n is in 1..33; no new request is taken until the last one is
//   committed to o_rsp
//   o_rsp is a register: the next request is accepted while a response
//   still waits; its result is held inside until o_rsp is free
//   reset (synchronous, active low) clears the accumulator to zero and
//   drops o_rsp.valid
// ----------------------------------------------------------------------------
module accumulator_arithmetic_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aau_req_if.sink   i_req,
    aau_rsp_if.source o_rsp
);
    import aau_pkg::*;

    t_dp_ctl    w_ctl;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_out_valid;
    t_word      w_value;
    logic       w_divide_error;

    // sequencer: decodes the request and steps the datapath loops
    aau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .i_command   (i_req.command),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_ctl       (w_ctl)
    );

    // datapath: accumulator, multiplier, divider, response register
    aau_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_operand      (t_word'(i_req.operand)),
        .o_status       (w_status),
        .o_value        (w_value),
        .o_divide_error (w_divide_error)
    );

    assign i_req.ready        = w_in_ready;
    assign o_rsp.valid        = w_out_valid;
    assign o_rsp.value        = w_value;
    assign o_rsp.divide_error = w_divide_error;

    // a response is only written when the output register is free
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == DP_COMMIT) |-> (!o_rsp.valid || o_rsp.ready))
        else $error("response register overwritten");

    // every commit shows up on the response channel
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == DP_COMMIT) |=> o_rsp.valid)
        else $error("commit without response");

    // one request in flight: no accept right after an accept
    a_single_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request taken while busy");

    // loops only run after a request was taken
    a_loop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == DP_DIV_STEP || w_ctl.op == DP_FACT_STEP) |-> !i_req.ready)
        else $error("loop running while idle");

endmodule

// ===== rtl/aau_dpath.sv =====
// ----------------------------------------------------------------------------
// aau_dpath
// accumulator, shared multiplier, restoring divider and output register
// ----------------------------------------------------------------------------
module aau_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aau_pkg::t_dp_ctl   i_ctl,
    input  aau_pkg::t_word     i_operand,
    output aau_pkg::t_dp_status o_status,
    output aau_pkg::t_word     o_value,
    output logic               o_divide_error
);
    import aau_pkg::*;

    t_word        r_acc;
    t_word        r_opnd;
    t_word        r_res;
    logic         r_err;
    t_word        r_x;
    t_word        r_y;
    t_word        r_quo;
    t_word        r_rem;
    t_word        r_dvs;
    logic [4:0]   r_dcnt;
    t_word        r_out_value;
    logic         r_out_err;

    t_word        w_prod;
    logic [DATA_W:0] w_shift;
    logic [DATA_W:0] w_diff;
    t_word        w_acc_mag;
    t_word        w_opnd_mag;
    logic         w_acc_le0;
    logic         w_acc_ge_lim;

    assign w_prod       = r_x * r_y;
    assign w_shift      = {r_rem, r_quo[DATA_W-1]};
    assign w_diff       = w_shift - {1'b0, r_dvs};
    assign w_acc_mag    = r_acc[DATA_W-1] ? (~r_acc + 1'b1) : r_acc;
    assign w_opnd_mag   = r_opnd[DATA_W-1] ? (~r_opnd + 1'b1) : r_opnd;
    assign w_acc_le0    = r_acc[DATA_W-1] || (r_acc == '0);
    assign w_acc_ge_lim = !r_acc[DATA_W-1] && (r_acc >= t_word'(FACT_LIMIT));

    always_comb begin
        o_status.fact_skip = w_acc_le0 || w_acc_ge_lim;
        o_status.fact_last = (r_y[5:0] == r_acc[5:0]);
        o_status.div_zero  = (r_opnd == '0);
        o_status.div_last  = &r_dcnt;
    end

    // accumulator is architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.op == DP_COMMIT) begin
            r_acc <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            DP_LOAD: begin
                r_opnd <= i_operand;
            end
            DP_ALU: begin
                r_err <= 1'b0;
                case (i_ctl.cmd)
                    CMD_ADD: r_res <= r_acc + r_opnd;
                    CMD_SUB: r_res <= r_acc - r_opnd;
                    CMD_CLR: r_res <= '0;
                    default: r_res <= r_acc;
                endcase
            end
            DP_MUL_INIT: begin
                r_x <= r_acc;
                r_y <= r_opnd;
            end
            DP_MUL_STEP: begin
                r_x <= w_prod;
            end
            DP_FACT_INIT: begin
                // trivial cases: 1 for n <= 0, 0 once 2^32 divides n!
                r_x <= (w_acc_ge_lim && !w_acc_le0) ? t_word'(0) : t_word'(1);
                r_y <= t_word'(1);
            end
            DP_FACT_STEP: begin
                r_x <= w_prod;
                r_y <= r_y + 1'b1;
            end
            DP_X_RES: begin
                r_res <= r_x;
                r_err <= 1'b0;
            end
            DP_DIV_ZERO: begin
                r_res <= r_acc;
                r_err <= 1'b1;
            end
            DP_DIV_INIT: begin
                r_quo  <= w_acc_mag;
                r_rem  <= '0;
                r_dvs  <= w_opnd_mag;
                r_dcnt <= '0;
            end
            DP_DIV_STEP: begin
                r_dcnt <= r_dcnt + 1'b1;
                if (!w_diff[DATA_W]) begin
                    r_rem <= w_diff[DATA_W-1:0];
                    r_quo <= {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[DATA_W-1:0];
                    r_quo <= {r_quo[DATA_W-2:0], 1'b0};
                end
            end
            DP_DIV_FIN: begin
                r_err <= 1'b0;
                if (i_ctl.cmd == CMD_DIV) begin
                    r_res <= (r_acc[DATA_W-1] ^ r_opnd[DATA_W-1]) ? (~r_quo + 1'b1) : r_quo;
                end else begin
                    r_res <= r_acc[DATA_W-1] ? (~r_rem + 1'b1) : r_rem;
                end
            end
            DP_COMMIT: begin
                r_out_value <= r_res;
                r_out_err   <= r_err;
            end
            default: begin
            end
        endcase
    end

    assign o_value        = r_out_value;
    assign o_divide_error = r_out_err;

endmodule

// ===== rtl/aau_ctrl.sv =====
// ----------------------------------------------------------------------------
// aau_ctrl
// sequencer: request intake, multi-cycle loops and response handshake
// ----------------------------------------------------------------------------
module aau_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [aau_pkg::CMD_W-1:0] i_command,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    input  aau_pkg::t_dp_status      i_status,
    output aau_pkg::t_dp_ctl         o_ctl
);
    import aau_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_FACT,
        S_X_RES,
        S_DIV,
        S_DIV_FIN,
        S_DONE
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [CMD_W-1:0] r_cmd;
    t_dp_op           w_op;
    logic             w_accept;
    logic             w_out_free;

    assign w_accept   = (r_state == S_IDLE) && i_in_valid;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        w_op        = DP_NONE;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op    = DP_LOAD;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_MUL: begin
                        w_op    = DP_MUL_INIT;
                        n_state = S_MUL;
                    end
                    CMD_FACT: begin
                        w_op    = DP_FACT_INIT;
                        n_state = i_status.fact_skip ? S_X_RES : S_FACT;
                    end
                    CMD_DIV, CMD_MOD: begin
                        if (i_status.div_zero) begin
                            w_op    = DP_DIV_ZERO;
                            n_state = S_DONE;
                        end else begin
                            w_op    = DP_DIV_INIT;
                            n_state = S_DIV;
                        end
                    end
                    default: begin
                        w_op    = DP_ALU;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_MUL: begin
                w_op    = DP_MUL_STEP;
                n_state = S_X_RES;
            end
            S_FACT: begin
                w_op = DP_FACT_STEP;
                if (i_status.fact_last) begin
                    n_state = S_X_RES;
                end
            end
            S_X_RES: begin
                w_op    = DP_X_RES;
                n_state = S_DONE;
            end
            S_DIV: begin
                w_op = DP_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = S_DIV_FIN;
                end
            end
            S_DIV_FIN: begin
                w_op    = DP_DIV_FIN;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_op        = DP_COMMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_ctl.op    = w_op;
    assign o_ctl.cmd   = r_cmd;

endmodule
